### design/fpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the framed packet receiver.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int BYTE_W = 8;
  localparam int OFF_W  = 6;

  // configuration register indexes
  localparam logic [0:0] CFG_OWN_ADDRESS = 1'b0;
  localparam logic [0:0] CFG_SYNC_BYTE   = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_len;      // length beat accepted and in range
    logic store;         // header/data beat accepted
    logic start_replay;  // good frame, rewind replay pointer
    logic replay;        // replay in progress
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sync_hit;
    logic len_ok;
    logic body_end;      // current beat is the checksum
    logic frame_ok;      // checksum matches and address passes
    logic replay_done;
  } status_t;

endpackage

### design/framed_packet_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_unit
// Sync/length/checksum deframer with address filter and buffered replay.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  rx      | in_valid, in_ready, rx_byte               | in
//  out     | out_valid, out_ready, out_byte,           | out
//          | byte_offset, last_byte                    |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
//  Hunt, length and body beats are taken one per cycle.
//  After a good checksum, input stalls while the frame store is replayed:
//  each result goes through a registered memory read, then the output register,
//  and the next read waits until the pending one has moved on; out_ready stalls hold it.
//  Reset clears config to zero and starts hunting; the frame store is not cleared.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module framed_packet_receiver_unit #(
  parameter int HEADER_BYTES   = 3,
  parameter int MAX_DATA_BYTES = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fpr_pkg::BYTE_W-1:0] rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fpr_pkg::BYTE_W-1:0] out_byte,
  output logic [fpr_pkg::OFF_W-1:0]  byte_offset,
  output logic                       last_byte,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [0:0]                 cfg_index,
  input  logic [fpr_pkg::BYTE_W-1:0] cfg_data
);

  fpr_pkg::cmd_t    cmd;
  fpr_pkg::status_t status;

  assign cfg_ready = 1'b1;

  fpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fpr_datapath #(
    .HEADER_BYTES   (HEADER_BYTES),
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .byte_offset (byte_offset),
    .last_byte   (last_byte)
  );

endmodule

### design/fpr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_datapath
// Config registers, frame store, checksum and replay output register.
// ----------------------------------------------------------------------------
module fpr_datapath #(
  parameter int HEADER_BYTES   = 3,
  parameter int MAX_DATA_BYTES = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [0:0]                 cfg_index,
  input  logic [fpr_pkg::BYTE_W-1:0] cfg_data,
  input  logic [fpr_pkg::BYTE_W-1:0] rx_byte,
  input  fpr_pkg::cmd_t              cmd,
  output fpr_pkg::status_t           status,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [fpr_pkg::BYTE_W-1:0] out_byte,
  output logic [fpr_pkg::OFF_W-1:0]  byte_offset,
  output logic                       last_byte
);

  localparam int STORE_DEPTH = HEADER_BYTES + MAX_DATA_BYTES;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [fpr_pkg::BYTE_W-1:0] LEN_MIN = fpr_pkg::BYTE_W'(HEADER_BYTES + 1);
  localparam logic [fpr_pkg::BYTE_W-1:0] LEN_MAX = fpr_pkg::BYTE_W'(STORE_DEPTH + 1);

  logic [fpr_pkg::BYTE_W-1:0] own_address;
  logic [fpr_pkg::BYTE_W-1:0] sync_byte;
  logic [CW-1:0]              body_len;
  logic [CW-1:0]              wr_cnt;
  logic [fpr_pkg::BYTE_W-1:0] running_sum;
  logic [fpr_pkg::BYTE_W-1:0] dest;
  logic [fpr_pkg::BYTE_W-1:0] mem [STORE_DEPTH];

  logic [CW-1:0]              rd_cnt;
  logic                       pend;
  logic [fpr_pkg::BYTE_W-1:0] mem_q;
  logic [fpr_pkg::OFF_W-1:0]  pend_off;
  logic                       pend_last;

  logic out_free;
  logic rd_more;
  logic rd_en;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
      sync_byte   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpr_pkg::CFG_OWN_ADDRESS: own_address <= cfg_data;
        fpr_pkg::CFG_SYNC_BYTE:   sync_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame capture
  always_ff @(posedge clk) begin
    if (rst) begin
      body_len    <= '0;
      wr_cnt      <= '0;
      running_sum <= '0;
    end else if (cmd.load_len) begin
      body_len    <= CW'(rx_byte - 8'd1);
      wr_cnt      <= '0;
      running_sum <= '0;
    end else if (cmd.store) begin
      wr_cnt      <= CW'(wr_cnt + 1'b1);
      running_sum <= running_sum + rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[wr_cnt[AW-1:0]] <= rx_byte;
      if (wr_cnt == '0) begin
        dest <= rx_byte;
      end
    end
  end

  // replay: read register, then output register
  assign out_free = !out_valid || out_ready;
  assign rd_more  = (rd_cnt != body_len);
  assign rd_en    = cmd.replay && rd_more && !pend && out_free;

  always_comb begin
    status.sync_hit    = (rx_byte == sync_byte);
    status.len_ok      = (rx_byte >= LEN_MIN) && (rx_byte <= LEN_MAX);
    status.body_end    = (wr_cnt == body_len);
    status.frame_ok    = (rx_byte == running_sum) &&
                         ((own_address == '0) || (dest == '0) || (dest == own_address));
    status.replay_done = cmd.replay && !rd_more && !pend && !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q     <= mem[rd_cnt[AW-1:0]];
      pend_off  <= fpr_pkg::OFF_W'(rd_cnt);
      pend_last <= (CW'(rd_cnt + 1'b1) == body_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt    <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start_replay) begin
        rd_cnt <= '0;
      end else if (rd_en) begin
        rd_cnt <= CW'(rd_cnt + 1'b1);
      end
      pend <= rd_en;
      if (pend) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      out_byte    <= mem_q;
      byte_offset <= pend_off;
      last_byte   <= pend_last;
    end
  end

  a_pend_slot_free: assert property (@(posedge clk) disable iff (rst)
    pend |-> !out_valid)
    else $error("read data pending while output register is full");

  a_no_store_in_replay: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> !cmd.replay)
    else $error("frame store written during replay");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_len |=> (body_len >= CW'(HEADER_BYTES)) && (body_len <= CW'(STORE_DEPTH)))
    else $error("body length out of range");

  a_last_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte) |-> (byte_offset == fpr_pkg::OFF_W'(body_len - 1'b1)))
    else $error("last beat at wrong offset");

endmodule

### design/fpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_ctrl
// Framing state machine: hunt, length, body, replay.
// ----------------------------------------------------------------------------
module fpr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fpr_pkg::status_t status,
  output fpr_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_HUNT   = 4'b0001,
    S_LEN    = 4'b0010,
    S_BODY   = 4'b0100,
    S_REPLAY = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   acc;

  assign in_ready = (state != S_REPLAY);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next       = state;
    cmd.load_len     = 1'b0;
    cmd.store        = 1'b0;
    cmd.start_replay = 1'b0;
    cmd.replay       = 1'b0;
    unique case (state)
      S_HUNT: begin
        if (acc && status.sync_hit) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (acc) begin
          if (status.len_ok) begin
            cmd.load_len = 1'b1;
            state_next   = S_BODY;
          end else begin
            state_next = S_HUNT;
          end
        end
      end
      S_BODY: begin
        if (acc) begin
          priority if (!status.body_end) begin
            cmd.store = 1'b1;
          end else if (status.frame_ok) begin
            cmd.start_replay = 1'b1;
            state_next       = S_REPLAY;
          end else begin
            state_next = S_HUNT;
          end
        end
      end
      S_REPLAY: begin
        cmd.replay = 1'b1;
        if (status.replay_done) begin
          state_next = S_HUNT;
        end
      end
      default: state_next = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule
